>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the ring node frame relay.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge out of reset.
`define RNFR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition on one edge implies a consequence on the next edge.
`define RNFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rnfr_pkg.sv
// ----------------------------------------------------------------------------
// rnfr_pkg
// Types, codes and constants shared by the ring node frame relay.
// ----------------------------------------------------------------------------
package rnfr_pkg;

    localparam int DEFAULT_PAYLOAD_DEPTH = 256;
    localparam int CMD_QUEUE_DEPTH       = 4;

    localparam logic [7:0] TOKEN_BYTE = 8'h31;
    localparam logic [7:0] FRAME_FLAG = 8'h30;

    typedef enum logic [2:0] {
        FUNC_RING   = 3'd0,
        FUNC_HEADER = 3'd1,
        FUNC_LOAD   = 3'd2,
        FUNC_STOP   = 3'd3,
        FUNC_START  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        OP_RING   = 3'd0,
        OP_HEADER = 3'd1,
        OP_LOAD   = 3'd2,
        OP_STOP   = 3'd3,
        OP_START  = 3'd4
    } op_t;

    typedef enum logic [5:0] {
        PH_FLAG = 6'b000001,
        PH_DEST = 6'b000010,
        PH_SRC  = 6'b000100,
        PH_LEN  = 6'b001000,
        PH_DATA = 6'b010000,
        PH_DONE = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] ring_byte;
        logic [7:0] dest_addr;
        logic [7:0] src_addr;
        logic [7:0] frame_length;
        logic [7:0] payload_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic [31:0] frames_received;
        logic [31:0] frames_sent;
        logic        frame_pending;
        logic        stopped;
    } rsp_item_t;

    typedef struct packed {
        logic [7:0] node_id;
    } cfg_item_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic [7:0] dest;
        logic [7:0] src;
        logic [7:0] len;
    } cmd_t;

    typedef struct packed {
        logic sending;
        logic pending;
        logic halted;
    } status_t;

endpackage

>>> sv/rnfr_chan_if.sv
// ----------------------------------------------------------------------------
// rnfr_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface rnfr_chan_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

>>> sv/rnfr_front.sv
// ----------------------------------------------------------------------------
// rnfr_front
// Accepts input transactions, decodes func and queues commands.
// ----------------------------------------------------------------------------
module rnfr_front (
    rnfr_chan_if.sink      req,
    output logic           push_valid,
    input  logic           push_ready,
    output rnfr_pkg::cmd_t push_data
);
    import rnfr_pkg::*;

    logic known;

    always_comb
    begin
        known          = 1'b1;
        push_data.op   = OP_RING;
        push_data.data = req.payload.ring_byte;
        push_data.dest = req.payload.dest_addr;
        push_data.src  = req.payload.src_addr;
        push_data.len  = req.payload.frame_length;
        case (req.payload.func)
            FUNC_RING:   push_data.op = OP_RING;
            FUNC_HEADER: push_data.op = OP_HEADER;
            FUNC_LOAD:
            begin
                push_data.op   = OP_LOAD;
                push_data.data = req.payload.payload_byte;
            end
            FUNC_STOP:   push_data.op = OP_STOP;
            FUNC_START:  push_data.op = OP_START;
            default:     known = 1'b0;
        endcase
    end

    // unused codes are taken and dropped
    assign push_valid = req.valid && known;
    assign req.ready  = push_ready;

endmodule

>>> sv/rnfr_cmd_queue.sv
// ----------------------------------------------------------------------------
// rnfr_cmd_queue
// Short FIFO of decoded commands between front and back.
// ----------------------------------------------------------------------------
module rnfr_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  rnfr_pkg::cmd_t push_data,
    output logic           pop_valid,
    input  logic           pop_ready,
    output rnfr_pkg::cmd_t pop_data
);
    import rnfr_pkg::*;

    localparam int PW = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(CMD_QUEUE_DEPTH + 1);

    cmd_t          entries_reg [CMD_QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(CMD_QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(CMD_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/rnfr_back.sv
// ----------------------------------------------------------------------------
// rnfr_back
// Executes commands: ring tracking, token capture, own frame send,
// payload store and the result register.
// ----------------------------------------------------------------------------
module rnfr_back #(
    parameter int PAYLOAD_DEPTH = rnfr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  rnfr_pkg::cmd_t    cmd,
    rnfr_chan_if.source       rsp,
    rnfr_chan_if.sink         cfg,
    output rnfr_pkg::status_t status
);
    import rnfr_pkg::*;

    localparam int AW  = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;
    localparam int LPW = $clog2(PAYLOAD_DEPTH + 1);

    logic [7:0]     payload_mem [PAYLOAD_DEPTH];

    logic [7:0]     node_id_reg;
    phase_t         rx_phase_reg, rx_phase_next;
    phase_t         tx_phase_reg, tx_phase_next;
    logic           sending_reg, sending_next;
    logic [7:0]     bytes_left_reg, bytes_left_next;
    logic [7:0]     tx_pos_reg, tx_pos_next;
    logic [LPW-1:0] load_pos_reg, load_pos_next;
    logic [7:0]     own_dest_reg, own_dest_next;
    logic [7:0]     own_src_reg, own_src_next;
    logic [7:0]     own_len_reg, own_len_next;
    logic           pending_reg, pending_next;
    logic [31:0]    rx_count_reg, rx_count_next;
    logic [31:0]    tx_count_reg, tx_count_next;
    logic           stop_req_reg, stop_req_next;
    logic           halted_reg, halted_next;

    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           out_mem_reg;
    logic [7:0]     rd_data_reg;

    logic           pop;
    logic           emit;
    logic [7:0]     byte_out;
    logic           from_mem;
    logic           mem_we;
    logic           use_own;
    phase_t         own_phase;
    logic [7:0]     pos_inc;
    logic [7:0]     bl_dec;

    assign cmd_ready = !out_valid_reg || rsp.ready;
    assign pop       = cmd_valid && cmd_ready;
    assign cfg.ready = 1'b1;

    assign pos_inc = tx_pos_reg + 8'd1;
    assign bl_dec  = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : 8'd0;

    always_comb
    begin
        rx_phase_next   = rx_phase_reg;
        tx_phase_next   = tx_phase_reg;
        sending_next    = sending_reg;
        bytes_left_next = bytes_left_reg;
        tx_pos_next     = tx_pos_reg;
        load_pos_next   = load_pos_reg;
        own_dest_next   = own_dest_reg;
        own_src_next    = own_src_reg;
        own_len_next    = own_len_reg;
        pending_next    = pending_reg;
        rx_count_next   = rx_count_reg;
        tx_count_next   = tx_count_reg;
        stop_req_next   = stop_req_reg;
        halted_next     = halted_reg;
        emit            = 1'b0;
        byte_out        = cmd.data;
        from_mem        = 1'b0;
        mem_we          = 1'b0;
        use_own         = sending_reg || (cmd.data == TOKEN_BYTE && pending_reg);
        own_phase       = sending_reg ? tx_phase_reg : PH_FLAG;

        case (cmd.op)
            OP_RING:
            begin
                if (!halted_reg)
                begin
                    emit = 1'b1;
                    case (rx_phase_reg)
                        PH_FLAG:
                        begin
                            if (use_own)
                            begin
                                sending_next = 1'b1;
                                case (own_phase)
                                    PH_FLAG:
                                    begin
                                        byte_out      = FRAME_FLAG;
                                        tx_phase_next = PH_DEST;
                                    end
                                    PH_DEST:
                                    begin
                                        byte_out      = own_dest_reg;
                                        tx_phase_next = PH_SRC;
                                    end
                                    PH_SRC:
                                    begin
                                        byte_out      = own_src_reg;
                                        tx_phase_next = PH_LEN;
                                    end
                                    PH_LEN:
                                    begin
                                        byte_out      = own_len_reg;
                                        tx_pos_next   = 8'd0;
                                        tx_phase_next = (own_len_reg == 8'd0) ? PH_DONE : PH_DATA;
                                    end
                                    PH_DATA:
                                    begin
                                        byte_out    = 8'd0;
                                        from_mem    = ({1'b0, tx_pos_reg} < 9'(PAYLOAD_DEPTH));
                                        tx_pos_next = pos_inc;
                                        if (pos_inc >= own_len_reg)
                                        begin
                                            tx_phase_next = PH_DONE;
                                        end
                                    end
                                    default:
                                    begin
                                        byte_out      = TOKEN_BYTE;
                                        tx_count_next = tx_count_reg + 32'd1;
                                        pending_next  = 1'b0;
                                        sending_next  = 1'b0;
                                        tx_pos_next   = 8'd0;
                                        tx_phase_next = PH_FLAG;
                                    end
                                endcase
                            end
                            else if (stop_req_reg)
                            begin
                                halted_next = 1'b1;
                            end
                            else if (cmd.data == FRAME_FLAG)
                            begin
                                rx_phase_next = PH_DEST;
                            end
                        end
                        PH_DEST:
                        begin
                            if (cmd.data == node_id_reg)
                            begin
                                rx_count_next = rx_count_reg + 32'd1;
                            end
                            rx_phase_next = PH_SRC;
                        end
                        PH_SRC:
                        begin
                            rx_phase_next = PH_LEN;
                        end
                        PH_LEN:
                        begin
                            bytes_left_next = cmd.data;
                            rx_phase_next   = (cmd.data == 8'd0) ? PH_FLAG : PH_DATA;
                        end
                        default:
                        begin
                            bytes_left_next = bl_dec;
                            if (bl_dec == 8'd0)
                            begin
                                rx_phase_next = PH_FLAG;
                            end
                        end
                    endcase
                end
            end
            OP_HEADER:
            begin
                if (!pending_reg && cmd.len != 8'd0)
                begin
                    own_dest_next = cmd.dest;
                    own_src_next  = cmd.src;
                    own_len_next  = cmd.len;
                    load_pos_next = '0;
                    pending_next  = 1'b1;
                end
            end
            OP_LOAD:
            begin
                if (!sending_reg && load_pos_reg < LPW'(PAYLOAD_DEPTH))
                begin
                    mem_we        = 1'b1;
                    load_pos_next = load_pos_reg + 1'b1;
                end
            end
            OP_STOP:
            begin
                stop_req_next = 1'b1;
            end
            OP_START:
            begin
                if (!halted_reg)
                begin
                    rx_phase_next = PH_FLAG;
                    tx_phase_next = PH_FLAG;
                    sending_next  = 1'b0;
                    tx_pos_next   = 8'd0;
                    if (node_id_reg == 8'd0)
                    begin
                        emit     = 1'b1;
                        byte_out = TOKEN_BYTE;
                    end
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_id_reg    <= 8'd0;
            rx_phase_reg   <= PH_FLAG;
            tx_phase_reg   <= PH_FLAG;
            sending_reg    <= 1'b0;
            bytes_left_reg <= 8'd0;
            tx_pos_reg     <= 8'd0;
            load_pos_reg   <= '0;
            own_dest_reg   <= 8'd0;
            own_src_reg    <= 8'd0;
            own_len_reg    <= 8'd0;
            pending_reg    <= 1'b0;
            rx_count_reg   <= 32'd0;
            tx_count_reg   <= 32'd0;
            stop_req_reg   <= 1'b0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                node_id_reg <= cfg.payload.node_id;
            end
            if (pop)
            begin
                rx_phase_reg   <= rx_phase_next;
                tx_phase_reg   <= tx_phase_next;
                sending_reg    <= sending_next;
                bytes_left_reg <= bytes_left_next;
                tx_pos_reg     <= tx_pos_next;
                load_pos_reg   <= load_pos_next;
                own_dest_reg   <= own_dest_next;
                own_src_reg    <= own_src_next;
                own_len_reg    <= own_len_next;
                pending_reg    <= pending_next;
                rx_count_reg   <= rx_count_next;
                tx_count_reg   <= tx_count_next;
                stop_req_reg   <= stop_req_next;
                halted_reg     <= halted_next;
            end
            out_valid_reg <= pop ? emit : (out_valid_reg && !rsp.ready);
        end
    end

    // payload store and result byte; no reset needed
    always_ff @(posedge clk)
    begin
        if (pop && mem_we)
        begin
            payload_mem[load_pos_reg[AW-1:0]] <= cmd.data;
        end
        if (pop && from_mem)
        begin
            rd_data_reg <= payload_mem[tx_pos_reg[AW-1:0]];
        end
        if (pop)
        begin
            out_byte_reg <= byte_out;
            out_mem_reg  <= from_mem;
        end
    end

    // state is frozen while a result waits, so counters are read live
    assign rsp.valid                   = out_valid_reg;
    assign rsp.payload.tx_byte         = out_mem_reg ? rd_data_reg : out_byte_reg;
    assign rsp.payload.frames_received = rx_count_reg;
    assign rsp.payload.frames_sent     = tx_count_reg;
    assign rsp.payload.frame_pending   = pending_reg;
    assign rsp.payload.stopped         = halted_reg;

    assign status.sending = sending_reg;
    assign status.pending = pending_reg;
    assign status.halted  = halted_reg;

endmodule

>>> sv/ring_node_frame_relay_core.sv
// ----------------------------------------------------------------------------
// ring_node_frame_relay_core
// Byte-wide token ring node: forwards and tracks ring frames, captures the
// token to send its own frame, counts received and sent frames.
//
//   channel  role    payload
//   req      sink    func, ring_byte, dest_addr, src_addr, frame_length,
//                    payload_byte
//   rsp      source  tx_byte, frames_received, frames_sent, frame_pending,
//                    stopped
//   cfg      sink    node_id (always ready)
//
// One transaction per cycle sustained on req and rsp while rsp.ready stays high.
// Path req to rsp: command queue, then result register.
// Command queue holds 4 entries; the back end stalls only while a result
// waits on rsp.ready. Payload store is read in the execute cycle and its
// registered data feeds tx_byte.
// rst_n clears control state at once; no clearing pass over the store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ring_node_frame_relay_core #(
    parameter int PAYLOAD_DEPTH = rnfr_pkg::DEFAULT_PAYLOAD_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    rnfr_chan_if.sink   req,
    rnfr_chan_if.source rsp,
    rnfr_chan_if.sink   cfg
);
    import rnfr_pkg::*;

    logic    push_valid, push_ready;
    cmd_t    push_data;
    logic    pop_valid, pop_ready;
    cmd_t    pop_data;
    status_t status;

    rnfr_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    rnfr_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rnfr_back #(
        .PAYLOAD_DEPTH (PAYLOAD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd_ready (pop_ready),
        .cmd       (pop_data),
        .rsp       (rsp),
        .cfg       (cfg),
        .status    (status)
    );

    `RNFR_ASSERT(a_send_has_frame, clk, rst_n, !status.sending || status.pending, "sending without pending frame")
    `RNFR_ASSERT(a_send_not_halted, clk, rst_n, !(status.sending && status.halted), "sending on halted node")
    `RNFR_ASSERT_NEXT(a_halt_sticky, clk, rst_n, status.halted, status.halted, "halted cleared")

endmodule
